FILE: sv/mctp_tx_packetizer_core_defines.svh
// Assertion macros for the packetizer RTL; only the framer uses them.
// Each check samples on the rising edge of clk and is disabled during reset.
`ifndef MCTP_TX_PACKETIZER_CORE_DEFINES_SVH
`define MCTP_TX_PACKETIZER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MTP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MTP_ASSERT_IMPL(lbl, ante, cons, msg) \
    `MTP_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define MTP_ASSERT(lbl, prop, msg)
`define MTP_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

FILE: sv/mtp_pkg.sv
`timescale 1ns / 1ps

package mtp_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int PHASE_W      = $clog2(HEADER_BYTES + 1);

    localparam logic [1:0] SEQ_FIELD_MASK = 2'b11;
    localparam logic [2:0] TAG_FIELD_MASK = 3'b111;
    localparam logic [7:0] HDR_VERSION    = 8'h01;

    localparam logic [7:0] LOCAL_EID_RESET   = 8'd8;
    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd64;

    // Register indexes, taken from paddr[2].
    localparam logic REG_LOCAL_EID   = 1'b0;
    localparam logic REG_MAX_PAYLOAD = 1'b1;

    // Header byte positions within a packet.
    localparam logic [PHASE_W-1:0] HDR_IDX_VER   = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] HDR_IDX_DEST  = PHASE_W'(1);
    localparam logic [PHASE_W-1:0] HDR_IDX_SRC   = PHASE_W'(2);
    localparam logic [PHASE_W-1:0] HDR_IDX_FLAGS = PHASE_W'(3);
    localparam logic [PHASE_W-1:0] HDR_IDX_DATA  = PHASE_W'(HEADER_BYTES);

    typedef struct packed {
        logic [7:0] local_eid;
        logic [7:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic        msg_start;
        logic [15:0] msg_len;
        logic [7:0]  dest_eid;
        logic        is_request;
        logic [2:0]  given_tag;
        logic        bridge;
        logic [7:0]  data;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       message_end;
        logic       run_end;
    } result_t;

endpackage

FILE: sv/mctp_tx_packetizer_core.sv
`timescale 1ns / 1ps
// The first result of an item passes the framer's input register, then the output register;
// a payload byte that opens a packet follows its four header bytes.
// Throughput: one item per cycle unless the output stalls; an item that opens a packet
// occupies the framer through its four header bytes and the payload byte, stalling input.
// The output register refills in the cycle it is taken; ready results go at one per cycle.
// Reset (rst_n low, asynchronous) empties both stages, clears the message state and
// restores local_eid to 8 and max_payload to 64.

module mctp_tx_packetizer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // From bit 0: msg_len[15:0], dest_eid[7:0], is_request, given_tag[2:0], bridge,
    // data[7:0], zero fill.
    input  logic [39:0] s_tdata,
    // Bit 0: msg_start.
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Bits 7:0: out_byte.
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    // Bit 0: message_end, bit 1: run_end.
    output logic [1:0]  m_tuser
);
    import mtp_pkg::*;

    cfg_t    cfg;
    item_t   in_item;
    result_t res;
    result_t out_res_reg;
    logic    res_valid;
    logic    out_valid_reg;
    logic    load_ok;

    assign in_item.msg_start  = s_tuser;
    assign in_item.msg_len    = s_tdata[15:0];
    assign in_item.dest_eid   = s_tdata[23:16];
    assign in_item.is_request = s_tdata[24];
    assign in_item.given_tag  = s_tdata[27:25];
    assign in_item.bridge     = s_tdata[28];
    assign in_item.data       = s_tdata[36:29];

    mtp_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign load_ok = !out_valid_reg || m_tready;

    mtp_framer u_framer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_item   (in_item),
        .in_ready  (s_tready),
        .res_ready (load_ok),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_ok)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.out_byte;
    assign m_tlast  = out_res_reg.packet_end;
    assign m_tuser  = {out_res_reg.run_end, out_res_reg.message_end};

endmodule

FILE: sv/mtp_apb_regs.sv
`timescale 1ns / 1ps

module mtp_apb_regs
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    output mtp_pkg::cfg_t cfg
);
    import mtp_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.local_eid   <= LOCAL_EID_RESET;
            cfg_reg.max_payload <= MAX_PAYLOAD_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_LOCAL_EID:   cfg_reg.local_eid   <= pwdata[7:0];
                REG_MAX_PAYLOAD: cfg_reg.max_payload <= pwdata[7:0];
                default:         cfg_reg.local_eid   <= cfg_reg.local_eid;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_LOCAL_EID:   prdata = {24'd0, cfg_reg.local_eid};
            REG_MAX_PAYLOAD: prdata = {24'd0, cfg_reg.max_payload};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

FILE: sv/mtp_framer.sv
`timescale 1ns / 1ps
`include "mctp_tx_packetizer_core_defines.svh"

module mtp_framer
(
    input  logic            clk,
    input  logic            rst_n,
    input  mtp_pkg::cfg_t   cfg,
    input  logic            in_valid,
    input  mtp_pkg::item_t  in_item,
    output logic            in_ready,
    input  logic            res_ready,
    output logic            res_valid,
    output mtp_pkg::result_t res
);
    import mtp_pkg::*;

    logic                in_valid_reg;
    item_t               item_reg;
    logic [PHASE_W-1:0]  phase_reg, phase_next;

    logic [15:0] bytes_left_reg,   bytes_left_next;
    logic [7:0]  packet_fill_reg,  packet_fill_next;
    logic [1:0]  packet_seq_reg,   packet_seq_next;
    logic [2:0]  owned_tag_reg,    owned_tag_next;
    logic [7:0]  held_dest_reg,    held_dest_next;
    logic        held_owner_reg,   held_owner_next;
    logic [2:0]  held_tag_reg,     held_tag_next;
    logic        held_bridge_reg,  held_bridge_next;
    logic        first_packet_reg, first_packet_next;

    // State as seen by the held item, with a message start applied.
    logic [15:0] eff_left;
    logic [7:0]  eff_fill;
    logic [1:0]  eff_seq;
    logic [7:0]  eff_dest;
    logic        eff_owner;
    logic [2:0]  eff_tag;
    logic        eff_bridge;
    logic        eff_first;

    logic [7:0]  limit;
    logic [8:0]  new_fill;
    logic        drop;
    logic        need_hdr;
    logic        final_res;
    logic        emit;
    logic        item_done;
    logic        mend;
    logic        pend;
    logic        eom;
    logic [2:0]  hdr_tag;
    logic [7:0]  flags;

    always_comb
    begin
        if (item_reg.msg_start)
        begin
            eff_left   = item_reg.msg_len;
            eff_fill   = 8'd0;
            eff_seq    = 2'd0;
            eff_dest   = item_reg.dest_eid;
            eff_owner  = item_reg.is_request;
            eff_tag    = item_reg.given_tag & TAG_FIELD_MASK;
            eff_bridge = item_reg.bridge;
            eff_first  = 1'b1;
        end
        else
        begin
            eff_left   = bytes_left_reg;
            eff_fill   = packet_fill_reg;
            eff_seq    = packet_seq_reg;
            eff_dest   = held_dest_reg;
            eff_owner  = held_owner_reg;
            eff_tag    = held_tag_reg;
            eff_bridge = held_bridge_reg;
            eff_first  = first_packet_reg;
        end
    end

    assign limit     = (cfg.max_payload == 8'd0) ? 8'd1 : cfg.max_payload;
    assign new_fill  = {1'b0, eff_fill} + 9'd1;
    assign drop      = in_valid_reg && (eff_left == 16'd0);
    assign need_hdr  = !eff_bridge && (eff_fill == 8'd0);
    assign final_res = !need_hdr || (phase_reg == HDR_IDX_DATA);
    assign emit      = in_valid_reg && !drop && res_ready;
    assign item_done = drop || (emit && final_res);
    assign in_ready  = !in_valid_reg || item_done;

    assign mend    = (eff_left == 16'd1);
    assign pend    = eff_bridge ? mend : (mend || (new_fill >= {1'b0, limit}));
    assign eom     = (eff_left <= {8'd0, limit});
    assign hdr_tag = eff_owner ? (owned_tag_reg & TAG_FIELD_MASK) : eff_tag;
    assign flags   = {eff_first, eom, eff_seq & SEQ_FIELD_MASK, eff_owner, hdr_tag};

    always_comb
    begin
        res_valid       = emit;
        res.packet_end  = 1'b0;
        res.message_end = 1'b0;
        res.run_end     = final_res;
        if (!need_hdr)
        begin
            res.out_byte = item_reg.data;
        end
        else
        begin
            case (phase_reg)
                HDR_IDX_VER:   res.out_byte = HDR_VERSION;
                HDR_IDX_DEST:  res.out_byte = eff_dest;
                HDR_IDX_SRC:   res.out_byte = cfg.local_eid;
                HDR_IDX_FLAGS: res.out_byte = flags;
                default:       res.out_byte = item_reg.data;
            endcase
        end
        if (final_res)
        begin
            res.packet_end  = pend;
            res.message_end = mend;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        bytes_left_next   = bytes_left_reg;
        packet_fill_next  = packet_fill_reg;
        packet_seq_next   = packet_seq_reg;
        owned_tag_next    = owned_tag_reg;
        held_dest_next    = held_dest_reg;
        held_owner_next   = held_owner_reg;
        held_tag_next     = held_tag_reg;
        held_bridge_next  = held_bridge_reg;
        first_packet_next = first_packet_reg;

        if (item_done)
        begin
            phase_next        = '0;
            bytes_left_next   = eff_left;
            packet_fill_next  = eff_fill;
            packet_seq_next   = eff_seq;
            held_dest_next    = eff_dest;
            held_owner_next   = eff_owner;
            held_tag_next     = eff_tag;
            held_bridge_next  = eff_bridge;
            first_packet_next = eff_first;
            if (!drop)
            begin
                bytes_left_next = eff_left - 16'd1;
                if (!eff_bridge)
                begin
                    if (mend)
                    begin
                        packet_fill_next  = 8'd0;
                        packet_seq_next   = 2'd0;
                        first_packet_next = 1'b1;
                        if (eff_owner)
                        begin
                            owned_tag_next = (owned_tag_reg + 3'd1) & TAG_FIELD_MASK;
                        end
                    end
                    else if (pend)
                    begin
                        packet_fill_next  = 8'd0;
                        packet_seq_next   = (eff_seq + 2'd1) & SEQ_FIELD_MASK;
                        first_packet_next = 1'b0;
                    end
                    else
                    begin
                        packet_fill_next = new_fill[7:0];
                    end
                end
            end
        end
        else if (emit)
        begin
            phase_next = phase_reg + PHASE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            phase_reg        <= '0;
            bytes_left_reg   <= 16'd0;
            packet_fill_reg  <= 8'd0;
            packet_seq_reg   <= 2'd0;
            owned_tag_reg    <= 3'd0;
            held_dest_reg    <= 8'd0;
            held_owner_reg   <= 1'b0;
            held_tag_reg     <= 3'd0;
            held_bridge_reg  <= 1'b0;
            first_packet_reg <= 1'b1;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (item_done)
            begin
                in_valid_reg <= 1'b0;
            end
            phase_reg        <= phase_next;
            bytes_left_reg   <= bytes_left_next;
            packet_fill_reg  <= packet_fill_next;
            packet_seq_reg   <= packet_seq_next;
            owned_tag_reg    <= owned_tag_next;
            held_dest_reg    <= held_dest_next;
            held_owner_reg   <= held_owner_next;
            held_tag_reg     <= held_tag_next;
            held_bridge_reg  <= held_bridge_next;
            first_packet_reg <= first_packet_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    `MTP_ASSERT_IMPL(a_phase_needs_item, phase_reg != '0, in_valid_reg,
                     "header phase without item")
    `MTP_ASSERT(a_phase_range, phase_reg <= HDR_IDX_DATA, "header phase out of range")
    `MTP_ASSERT_IMPL(a_mid_message_left, !first_packet_reg, bytes_left_reg != 16'd0,
                     "continuation packet with no bytes left")
    `MTP_ASSERT_IMPL(a_tag_advance, owned_tag_reg != $past(owned_tag_reg),
                     $past(emit && mend && eff_owner),
                     "owned tag moved without a request ending")

endmodule

FILE: verif/mctp_frame_checker.sv
`timescale 1ns / 1ps

module mctp_frame_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser,
    output int          errors,
    output int          outstanding
);
    import mtp_pkg::*;

    result_t predicted_stream[$];

    logic [7:0]  src_eid;
    logic [7:0]  payload_cap;
    logic [15:0] msg_remaining;
    logic [7:0]  fill;
    logic [1:0]  seq;
    logic [2:0]  req_tag;
    logic [7:0]  dest;
    logic        owner;
    logic [2:0]  resp_tag;
    logic        pass_thru;
    logic        som_pending;

    function automatic void push_byte(input logic [7:0] value, input logic pend,
                                      input logic mend, input logic last);
        result_t r;
        r.out_byte    = value;
        r.packet_end  = pend;
        r.message_end = mend;
        r.run_end     = last;
        predicted_stream.push_back(r);
    endfunction

    function automatic void frame_byte(input item_t it);
        logic [7:0] cap;
        logic [2:0] tag;
        logic       eom;
        logic       last_in_pkt;
        logic       last_in_msg;
        cap = (payload_cap == 8'd0) ? 8'd1 : payload_cap;
        if (it.msg_start)
        begin
            msg_remaining = it.msg_len;
            dest          = it.dest_eid;
            owner         = it.is_request;
            resp_tag      = it.given_tag;
            pass_thru     = it.bridge;
            fill          = 8'd0;
            seq           = 2'd0;
            som_pending   = 1'b1;
        end
        if (msg_remaining == 16'd0)
            return;
        if (pass_thru)
        begin
            last_in_msg   = (msg_remaining == 16'd1);
            msg_remaining = msg_remaining - 16'd1;
            push_byte(it.data, last_in_msg, last_in_msg, 1'b1);
            return;
        end
        if (fill == 8'd0)
        begin
            tag = owner ? (req_tag & TAG_FIELD_MASK) : resp_tag;
            eom = (msg_remaining <= {8'd0, cap});
            push_byte(HDR_VERSION, 1'b0, 1'b0, 1'b0);
            push_byte(dest, 1'b0, 1'b0, 1'b0);
            push_byte(src_eid, 1'b0, 1'b0, 1'b0);
            push_byte({som_pending, eom, seq & SEQ_FIELD_MASK, owner, tag}, 1'b0, 1'b0, 1'b0);
        end
        fill          = fill + 8'd1;
        msg_remaining = msg_remaining - 16'd1;
        last_in_msg   = (msg_remaining == 16'd0);
        last_in_pkt   = last_in_msg || (fill >= cap);
        push_byte(it.data, last_in_pkt, last_in_msg, 1'b1);
        if (last_in_pkt)
        begin
            fill        = 8'd0;
            seq         = seq + 2'd1;
            som_pending = 1'b0;
        end
        if (last_in_msg)
        begin
            if (owner)
                req_tag = req_tag + 3'd1;
            som_pending = 1'b1;
            seq         = 2'd0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        item_t   it;
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            src_eid       = LOCAL_EID_RESET;
            payload_cap   = MAX_PAYLOAD_RESET;
            msg_remaining = 16'd0;
            fill          = 8'd0;
            seq           = 2'd0;
            req_tag       = 3'd0;
            dest          = 8'd0;
            owner         = 1'b0;
            resp_tag      = 3'd0;
            pass_thru     = 1'b0;
            som_pending   = 1'b1;
            errors        = 0;
            predicted_stream.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_LOCAL_EID)
                    src_eid = pwdata[7:0];
                else
                    payload_cap = pwdata[7:0];
            end
            if (m_tvalid && m_tready)
            begin
                got.out_byte    = m_tdata;
                got.packet_end  = m_tlast;
                got.message_end = m_tuser[0];
                got.run_end     = m_tuser[1];
                if (predicted_stream.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t: unexpected result, expected none, got byte %h tlast %b tuser %b",
                             $time, m_tdata, m_tlast, m_tuser);
                end
                else
                begin
                    want = predicted_stream.pop_front();
                    if (got.out_byte !== want.out_byte || got.packet_end !== want.packet_end ||
                        got.message_end !== want.message_end || got.run_end !== want.run_end)
                    begin
                        errors = errors + 1;
                        $display("%0t: mismatch, expected byte %h pend %b mend %b last %b,",
                                 $time, want.out_byte, want.packet_end, want.message_end,
                                 want.run_end);
                        $display("%0t:   got byte %h pend %b mend %b last %b",
                                 $time, got.out_byte, got.packet_end, got.message_end,
                                 got.run_end);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                it.msg_start  = s_tuser;
                it.msg_len    = s_tdata[15:0];
                it.dest_eid   = s_tdata[23:16];
                it.is_request = s_tdata[24];
                it.given_tag  = s_tdata[27:25];
                it.bridge     = s_tdata[28];
                it.data       = s_tdata[36:29];
                frame_byte(it);
            end
        end
        outstanding = predicted_stream.size();
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import mtp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    int errors;
    int outstanding;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int open_left = 0;
    int items_done = 0;
    int target;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    int idle_plan[4]  = '{0, 45, 0, 32};
    int stall_plan[4] = '{0, 0, 45, 32};
    int cap_plan[4]   = '{1, 255, 0, 3};

    mctp_tx_packetizer_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    mctp_frame_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready  <= 1'b0;
                hold_left = hold_left - 1;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 300;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_item(input logic start, input logic [15:0] len, input logic [7:0] dest,
                             input logic owner, input logic [2:0] tag, input logic brg,
                             input logic [7:0] payload);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {3'b000, payload, brg, tag, owner, dest, len};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic settle(input int extra);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_item();
        int          r;
        int          pick;
        logic [15:0] len;
        r = $urandom_range(99);
        if (open_left == 0 && r < 6)
            send_item(1'b0, 16'($urandom), 8'($urandom), 1'($urandom), 3'($urandom),
                      1'($urandom), 8'($urandom));
        else if (r < 10)
        begin
            send_item(1'b1, 16'd0, 8'($urandom), 1'($urandom), 3'($urandom),
                      1'($urandom), 8'($urandom));
            open_left = 0;
        end
        else if (open_left == 0 || r < 13)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                len = 16'($urandom_range(65535, 1));
            else if (pick < 70)
                len = 16'($urandom_range(12, 1));
            else if (pick < 90)
                len = 16'($urandom_range(40, 13));
            else
                len = 16'($urandom_range(300, 41));
            send_item(1'b1, len, 8'($urandom), 1'($urandom), 3'($urandom),
                      ($urandom_range(99) < 15), 8'($urandom));
            open_left  = len - 1;
            items_done = items_done + 1;
        end
        else
        begin
            send_item(1'b0, 16'($urandom), 8'($urandom), 1'($urandom), 3'($urandom),
                      1'($urandom), 8'($urandom));
            open_left  = open_left - 1;
            items_done = items_done + 1;
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 3'd0;
        pwdata   = 32'd0;
        s_tvalid = 1'b0;
        s_tdata  = 40'd0;
        s_tuser  = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(1'b0, 16'hFFFF, 8'hFF, 1'b1, 3'h7, 1'b1, 8'hFF);
        send_item(1'b1, 16'h0000, 8'hFF, 1'b1, 3'h7, 1'b0, 8'h00);
        send_item(1'b1, 16'd3, 8'hFF, 1'b1, 3'h0, 1'b0, 8'h00);
        send_item(1'b0, 16'h0000, 8'h00, 1'b0, 3'h0, 1'b0, 8'hFF);
        send_item(1'b0, 16'hFFFF, 8'hFF, 1'b1, 3'h7, 1'b1, 8'h5A);
        send_item(1'b1, 16'd1, 8'h00, 1'b0, 3'h7, 1'b0, 8'hFF);
        send_item(1'b1, 16'd2, 8'h12, 1'b1, 3'h5, 1'b0, 8'hA5);
        send_item(1'b0, 16'd0, 8'h00, 1'b0, 3'h0, 1'b0, 8'h3C);
        send_item(1'b1, 16'd3, 8'h34, 1'b0, 3'h2, 1'b1, 8'h01);
        send_item(1'b0, 16'd0, 8'h00, 1'b0, 3'h0, 1'b0, 8'h02);
        send_item(1'b0, 16'd0, 8'h00, 1'b0, 3'h0, 1'b0, 8'h03);
        send_item(1'b1, 16'hFFFF, 8'hFF, 1'b1, 3'h7, 1'b0, 8'hC3);
        send_item(1'b0, 16'd0, 8'h00, 1'b0, 3'h0, 1'b0, 8'h11);
        send_item(1'b0, 16'd0, 8'h00, 1'b0, 3'h0, 1'b0, 8'h22);
        send_item(1'b1, 16'd2, 8'h56, 1'b0, 3'h0, 1'b0, 8'h44);
        send_item(1'b0, 16'd0, 8'h00, 1'b0, 3'h0, 1'b0, 8'h55);
        send_item(1'b1, 16'd5, 8'h78, 1'b1, 3'h1, 1'b0, 8'h66);
        send_item(1'b1, 16'd0, 8'h9A, 1'b0, 3'h3, 1'b0, 8'h77);
        send_item(1'b0, 16'd4, 8'hBC, 1'b1, 3'h4, 1'b0, 8'h88);
        open_left = 0;

        for (int p = 0; p < 4; p++)
        begin
            settle(8);
            src_idle_pct   = idle_plan[p];
            sink_stall_pct = stall_plan[p];
            if (p == 0)
                apb_write(REG_LOCAL_EID, 8'h00);
            else if (p == 1)
                apb_write(REG_LOCAL_EID, 8'hFF);
            else
                apb_write(REG_LOCAL_EID, 8'($urandom));
            apb_write(REG_MAX_PAYLOAD, 8'(cap_plan[p]));
            target = items_done + 90;
            while (items_done < target)
            begin
                if (p == 0 && !hold_done && items_done >= target - 70)
                begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                random_item();
            end
        end

        settle(20);
        if (errors == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/mtp_pkg.sv
sv/mtp_apb_regs.sv
sv/mtp_framer.sv
sv/mctp_tx_packetizer_core.sv
verif/mctp_frame_checker.sv
verif/tb.sv
